>>> rtl/core/akt_pkg.sv
// ----------------------------------------------------------------------------
// akt_pkg
// Shared types and constants for the authorised key table.
// ----------------------------------------------------------------------------
`default_nettype none

package akt_pkg;

    localparam int KEY_W   = 96;
    localparam int COUNT_W = 5;
    localparam int OUT_W   = 8;

    typedef logic [KEY_W-1:0] key_t;

    localparam key_t ADMIN_KEY_0 = {12{8'hFF}};
    localparam key_t ADMIN_KEY_1 = {12{8'hCC}};

    localparam logic MODE_LOOKUP = 1'b0;
    localparam logic MODE_ADD    = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic dispatch;
        logic scan_issue;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic mode_add;
        logic scan_needed;
        logic scan_last;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

>>> rtl/core/authorized_key_table.sv
// ----------------------------------------------------------------------------
// authorized_key_table
// Table of 96-bit access keys with lookup and append requests.
// ----------------------------------------------------------------------------
//  channel | direction | payload
//  s_      | in        | tuser: mode; tdata: key_upper, key_lower
//  m_      | out       | tdata: is_authorized, is_admin, add_ok, key_count
//
//  an add, or a lookup with only the admin keys stored, goes from dispatch straight to finish
//  any other lookup passes through scan and then drain: one key store read per cycle
//  the result is loaded into the result register in finish, once that register is free
//  admin keys are fixed constants, so reset is immediate and needs no fill
//  a waiting result does not stop the next request from being taken, but that
//  request then holds in finish until the result register drains
// ----------------------------------------------------------------------------
`default_nettype none

module authorized_key_table #(
    parameter int MAX_KEYS        = 16,
    parameter int ADMIN_KEY_COUNT = 2
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [95:0]  s_tdata,  // key_upper[31:0], key_lower[95:32]
    input  wire logic         s_tuser,  // mode
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [7:0]        m_tdata   // is_authorized, is_admin, add_ok, key_count[7:3]
);

    akt_pkg::cmd_t    cmd;
    akt_pkg::status_t status;
    akt_pkg::key_t    in_key;

    assign in_key = {s_tdata[31:0], s_tdata[95:32]};

    akt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    akt_datapath #(
        .MAX_KEYS        (MAX_KEYS),
        .ADMIN_KEY_COUNT (ADMIN_KEY_COUNT)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_key   (in_key),
        .in_mode  (s_tuser),
        .cmd      (cmd),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

>>> rtl/core/akt_ctrl.sv
// ----------------------------------------------------------------------------
// akt_ctrl
// Request sequencer: accept, dispatch, table scan and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module akt_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire akt_pkg::status_t status,
    output akt_pkg::cmd_t         cmd
);

    akt_pkg::state_t state_reg;
    akt_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= akt_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            akt_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = akt_pkg::ST_DISPATCH;
                end
            end
            akt_pkg::ST_DISPATCH: begin
                cmd.dispatch = 1'b1;
                if (status.mode_add || !status.scan_needed) begin
                    state_next = akt_pkg::ST_FINISH;
                end else begin
                    state_next = akt_pkg::ST_SCAN;
                end
            end
            akt_pkg::ST_SCAN: begin
                cmd.scan_issue = 1'b1;
                if (status.scan_last) begin
                    state_next = akt_pkg::ST_DRAIN;
                end
            end
            akt_pkg::ST_DRAIN: begin
                state_next = akt_pkg::ST_FINISH;
            end
            akt_pkg::ST_FINISH: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = akt_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = akt_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/core/akt_datapath.sv
// ----------------------------------------------------------------------------
// akt_datapath
// Key store, request registers, scan compare and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module akt_datapath #(
    parameter int MAX_KEYS        = 16,
    parameter int ADMIN_KEY_COUNT = 2
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire akt_pkg::key_t                in_key,
    input  wire logic                         in_mode,
    input  wire akt_pkg::cmd_t                cmd,
    output akt_pkg::status_t                  status,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic [akt_pkg::OUT_W-1:0]         m_tdata
);

    localparam int AW = $clog2(MAX_KEYS);
    localparam int CW = $clog2(MAX_KEYS + 1);

    akt_pkg::key_t key_store [MAX_KEYS];

    akt_pkg::key_t          key_reg;
    logic                   mode_reg;
    logic [CW-1:0]          count_reg;
    logic [CW-1:0]          count_next;
    logic [AW-1:0]          addr_reg;
    akt_pkg::key_t          rd_data_reg;
    logic                   rd_valid_reg;
    logic                   hit_reg;
    logic                   admin_reg;
    logic                   ok_reg;
    logic                   m_valid_reg;
    logic [akt_pkg::OUT_W-1:0] m_data_reg;

    logic                   admin_match;
    logic                   full;
    logic                   do_write;
    logic [31:0]            count_ext;

    assign admin_match = ((ADMIN_KEY_COUNT > 0) && (key_reg == akt_pkg::ADMIN_KEY_0)) ||
                         ((ADMIN_KEY_COUNT > 1) && (key_reg == akt_pkg::ADMIN_KEY_1));
    assign full        = (count_reg >= CW'(MAX_KEYS));
    assign do_write    = cmd.dispatch && mode_reg && !full;
    assign count_next  = do_write ? count_reg + CW'(1) : count_reg;
    assign count_ext   = 32'(count_reg);

    assign status.mode_add    = mode_reg;
    assign status.scan_needed = (count_reg > CW'(ADMIN_KEY_COUNT));
    assign status.scan_last   = ((CW'(addr_reg) + CW'(1)) == count_reg);
    assign status.out_free    = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (do_write) begin
            key_store[count_reg[AW-1:0]] <= key_reg;
        end
        rd_data_reg <= key_store[addr_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= CW'(ADMIN_KEY_COUNT);
            rd_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            count_reg    <= count_next;
            rd_valid_reg <= cmd.scan_issue;
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            key_reg  <= in_key;
            mode_reg <= in_mode;
        end
        if (cmd.dispatch) begin
            addr_reg  <= AW'(ADMIN_KEY_COUNT);
            admin_reg <= admin_match;
            hit_reg   <= admin_match;
            ok_reg    <= mode_reg && !full;
        end else begin
            if (cmd.scan_issue) begin
                addr_reg <= addr_reg + AW'(1);
            end
            if (rd_valid_reg && (rd_data_reg == key_reg)) begin
                hit_reg <= 1'b1;
            end
        end
        if (cmd.out_load) begin
            m_data_reg <= {count_ext[akt_pkg::COUNT_W-1:0],
                           ok_reg && (mode_reg == akt_pkg::MODE_ADD),
                           admin_reg && (mode_reg == akt_pkg::MODE_LOOKUP),
                           hit_reg && (mode_reg == akt_pkg::MODE_LOOKUP)};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

`default_nettype wire
